FILE: src/mta_pkg.sv
// ----------------------------------------------------------------------------
// mta_pkg - shared types and constants for the mask-to-alpha converter
// Pixel layout, configuration register indexes and the words passed between
// the pixel rule and the output stage.
// ----------------------------------------------------------------------------
package mta_pkg;

  localparam int PIXEL_W          = 32;
  localparam int COLOR_W          = 24;
  localparam int ALPHA_W          = 8;
  localparam int CFG_W            = 13;
  localparam int CFG_INDEX_W      = 3;
  localparam int MAX_SIDE_DEFAULT = 4096;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MASK_WIDTH      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MASK_HEIGHT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_MASK_MODE = 3'd4;

  localparam logic [COLOR_W-1:0] COLOR_WHITE  = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] COLOR_BLACK  = 24'h000000;
  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 8'h00;

  // Outcome of the per-pixel rule
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               conflict;
  } mta_rule_t;

  // One result word as held in the output stage
  typedef struct packed {
    logic [PIXEL_W-1:0] result_pixel;
    logic               pixel_conflict;
    logic               last_pixel;
    logic               all_clear;
  } mta_word_t;

endpackage

FILE: src/mask_to_alpha_converter.sv
// ----------------------------------------------------------------------------
// mask_to_alpha_converter - BGRA image plus mask to alpha-keyed image
// Streams image and mask pixel pairs in raster order and emits converted
// pixels with a per-image conflict summary on the last pixel.
// ----------------------------------------------------------------------------
// The block takes one image/mask word pair per cycle while in_stall is low
// and returns one registered result word per pair, in order. Column
// and row counters locate each pixel and decide whether it falls inside the
// mask; the pixel rule and the counter update are combinational logic feeding
// an output register, so it sustains one word per clock unless stalled. A skid
// register behind the output keeps input acceptance going for one more word
// while the output is stalled; in_stall rises only once both are full.
// Consumers should commit an image only when all_clear is 1 on the word with
// last_pixel set. Image sizes of 0 act as 1, sizes above MAX_SIDE act as
// MAX_SIDE. Write configuration only between images, while the block is idle.
// ----------------------------------------------------------------------------
module mask_to_alpha_converter import mta_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [PIXEL_W-1:0]     image_pixel,
  input  logic [PIXEL_W-1:0]     mask_pixel,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PIXEL_W-1:0]     result_pixel,
  output logic                   pixel_conflict,
  output logic                   last_pixel,
  output logic                   all_clear
);

  // counters only ever hold 0 .. MAX_SIDE-1
  localparam int CNT_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;
  localparam logic [CMP_W-1:0] SIDE_MAX = CMP_W'(MAX_SIDE);
  localparam logic [CMP_W-1:0] SIDE_MIN = CMP_W'(1);

  // configuration registers
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [CFG_W-1:0] mask_width;
  logic [CFG_W-1:0] mask_height;
  logic             alpha_mask_mode;

  // position and conflict tracking
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic             conflict_seen;
  logic [CNT_W-1:0] column_count_next;
  logic [CNT_W-1:0] row_count_next;
  logic             conflict_seen_next;

  // output register and skid register
  mta_word_t        out_word;
  mta_word_t        skid_word;
  logic             skid_valid;
  mta_word_t        word_next;

  logic [CMP_W-1:0] width_ext;
  logic [CMP_W-1:0] height_ext;
  logic [CMP_W-1:0] width_clamp;
  logic [CMP_W-1:0] height_clamp;
  logic [CMP_W-1:0] col_ext;
  logic [CMP_W-1:0] row_ext;
  logic             last_col;
  logic             last_row;
  logic             last;
  logic             in_mask;
  logic             in_accept;
  logic             out_take;
  mta_rule_t        rule;

  // --------------------------------------------------------------------------
  // Configuration: writes to an index past the list drop silently
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= CFG_W'(1);
      image_height    <= CFG_W'(1);
      mask_width      <= '0;
      mask_height     <= '0;
      alpha_mask_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     image_width     <= cfg_data;
        REG_IMAGE_HEIGHT:    image_height    <= cfg_data;
        REG_MASK_WIDTH:      mask_width      <= cfg_data;
        REG_MASK_HEIGHT:     mask_height     <= cfg_data;
        REG_ALPHA_MASK_MODE: alpha_mask_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Position: clamp the image size, find the last column and row
  // --------------------------------------------------------------------------
  assign width_ext  = CMP_W'(image_width);
  assign height_ext = CMP_W'(image_height);

  always_comb begin
    width_clamp = width_ext;
    if (width_ext < SIDE_MIN) begin
      width_clamp = SIDE_MIN;
    end else if (width_ext > SIDE_MAX) begin
      width_clamp = SIDE_MAX;
    end
    height_clamp = height_ext;
    if (height_ext < SIDE_MIN) begin
      height_clamp = SIDE_MIN;
    end else if (height_ext > SIDE_MAX) begin
      height_clamp = SIDE_MAX;
    end
  end

  assign col_ext  = CMP_W'(column_count);
  assign row_ext  = CMP_W'(row_count);
  // ">=" so a counter past a freshly shrunk size still wraps
  assign last_col = col_ext >= (width_clamp - SIDE_MIN);
  assign last_row = row_ext >= (height_clamp - SIDE_MIN);
  assign last     = last_col && last_row;
  assign in_mask  = (col_ext < CMP_W'(mask_width)) && (row_ext < CMP_W'(mask_height));

  // --------------------------------------------------------------------------
  // Pixel rule
  // --------------------------------------------------------------------------
  mta_pixel_rule u_rule (
    .alpha_mode  (alpha_mask_mode),
    .in_mask     (in_mask),
    .image_pixel (image_pixel),
    .mask_pixel  (mask_pixel),
    .rule        (rule)
  );

  // sticky conflict; all_clear only reports on the last pixel
  assign conflict_seen_next = last ? 1'b0 : (conflict_seen | rule.conflict);

  always_comb begin
    word_next.result_pixel   = rule.pixel;
    word_next.pixel_conflict = rule.conflict;
    word_next.last_pixel     = last;
    word_next.all_clear      = last && !(conflict_seen | rule.conflict);
  end

  // advance raster position
  always_comb begin
    column_count_next = column_count + CNT_W'(1);
    row_count_next    = row_count;
    if (last_col) begin
      column_count_next = '0;
      row_count_next    = last_row ? '0 : (row_count + CNT_W'(1));
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: output register with a one-word skid behind it
  // --------------------------------------------------------------------------
  assign in_accept = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      conflict_seen <= 1'b0;
      out_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (in_accept) begin
        column_count  <= column_count_next;
        row_count     <= row_count_next;
        conflict_seen <= conflict_seen_next;
      end
      if (out_take || !out_valid) begin
        // output free: refill from skid first, else straight from input
        if (skid_valid) begin
          out_word   <= skid_word;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else if (in_accept) begin
          out_word  <= word_next;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (in_accept) begin
        // output held: park the new word in the skid
        skid_word  <= word_next;
        skid_valid <= 1'b1;
      end
    end
  end

  assign result_pixel   = out_word.result_pixel;
  assign pixel_conflict = out_word.pixel_conflict;
  assign last_pixel     = out_word.last_pixel;
  assign all_clear      = out_word.all_clear;

endmodule

FILE: src/mta_pixel_rule.sv
// ----------------------------------------------------------------------------
// mta_pixel_rule - per-pixel colour or alpha mask rule
// Turns one image/mask pixel pair into the converted pixel and its conflict.
// ----------------------------------------------------------------------------
module mta_pixel_rule import mta_pkg::*; (
  input  logic               alpha_mode,
  input  logic               in_mask,
  input  logic [PIXEL_W-1:0] image_pixel,
  input  logic [PIXEL_W-1:0] mask_pixel,
  output mta_rule_t          rule
);

  logic [COLOR_W-1:0] img_color;
  logic [COLOR_W-1:0] msk_color;
  logic [ALPHA_W-1:0] msk_alpha;
  logic [PIXEL_W-1:0] opaque_pixel;

  assign img_color    = image_pixel[COLOR_W-1:0];
  assign msk_color    = in_mask ? mask_pixel[COLOR_W-1:0] : COLOR_BLACK;
  assign msk_alpha    = in_mask ? mask_pixel[PIXEL_W-1:COLOR_W] : ALPHA_OPAQUE;
  assign opaque_pixel = {ALPHA_OPAQUE, img_color};

  always_comb begin
    rule.pixel    = opaque_pixel;
    rule.conflict = 1'b0;
    if (alpha_mode) begin
      if (msk_alpha == ALPHA_CLEAR) begin
        rule.pixel = '0;
      end
    end else if (img_color == COLOR_BLACK && msk_color == COLOR_WHITE) begin
      rule.pixel = '0;
    end else begin
      // flag image bits that are clear where the mask bit is set
      rule.conflict = |(~img_color & msk_color);
    end
  end

endmodule

FILE: src/mta_checker.sv
// ----------------------------------------------------------------------------
// mta_checker - port-level checks for the mask-to-alpha converter
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
module mta_checker import mta_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [PIXEL_W-1:0]     result_pixel,
  input logic                   pixel_conflict,
  input logic                   last_pixel,
  input logic                   all_clear
);

  // all_clear is a last-pixel summary only
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_pixel |-> !all_clear)
    else $error("all_clear set on a pixel that is not last");

  // a conflict never comes with a transparent pixel
  a_conflict_opaque: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_conflict |-> result_pixel[PIXEL_W-1 -: ALPHA_W] == ALPHA_OPAQUE)
    else $error("conflict on a pixel that is not opaque");

  // results are either all zero or fully opaque
  a_alpha_binary: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_pixel != '0 |-> result_pixel[PIXEL_W-1 -: ALPHA_W] == ALPHA_OPAQUE)
    else $error("result pixel with partial alpha");

  // a stalled result word holds its pixel, last_pixel and all_clear
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_pixel)
      && $stable(last_pixel) && $stable(all_clear))
    else $error("stalled output word changed");

endmodule

bind mask_to_alpha_converter mta_checker u_mta_checker (.*);
